### src/rdm_pkg.sv
// ----------------------------------------------------------------------------
// rdm_pkg
// Shared types and constants for the ring DFT magnitude block.
// ----------------------------------------------------------------------------
package rdm_pkg;

    localparam int CFG_W      = 11;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int MAX_HEIGHT = 1024;
    localparam int NBINS      = 5;
    localparam int COS45_Q16  = 46341;

    // re/im components in Q16: A*65536 + B*46341, A,B within +-2040
    localparam int AB_W   = 13;
    localparam int Q_W    = 31;
    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    // classified request handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] x0, x1, x2, x3, x4, x5, x6, x7;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic             last;
    } rdm_req_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_LOAD,
        SQ_RUN,
        SQ_DONE
    } rdm_state_t;

endpackage

### src/ring_dft_magnitude_3x3.sv
// ----------------------------------------------------------------------------
// ring_dft_magnitude_3x3
// 3x3 ring 8-point DFT magnitude of a grayscale pixel stream.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                          | tuser
// s_      | in  | pixel[7:0]                                  | start_of_frame
// m_      | out | mag_k0..mag_k4, center_x, center_y (64 bits)| last_of_frame
//
// Front takes one pixel per cycle until its output register is held by a
// full queue.
// Back end takes one interior result at a time: accept, load phases,
// 31 bit-serial root steps (one root per bin, all in parallel), then output.
// aresetn clears counters, window, queue and back-end state; line stores
// are not cleared. Output holds until m_tready.
module ring_dft_magnitude_3x3
    import rdm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int NUM_FREQ  = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // pixel
    input  logic             s_tuser,   // start_of_frame
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // mag_k0..mag_k4, center_x, center_y
    output logic             m_tuser,   // last_of_frame
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);
    logic [CFG_W-1:0] width_reg, height_reg;
    logic             f2q_valid, f2q_ready, q2b_valid, q2b_ready;
    rdm_req_t         f_req, q_req;
    logic [8*NBINS-1:0] mags;
    logic [POS_W-1:0]   cx, cy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rdm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk, .aresetn,
        .width_cfg(width_reg), .height_cfg(height_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .pixel(s_tdata), .sof(s_tuser),
        .req_valid(f2q_valid), .req_ready(f2q_ready), .req(f_req)
    );

    rdm_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid(f2q_valid), .wr_ready(f2q_ready), .wr_data(f_req),
        .rd_valid(q2b_valid), .rd_ready(q2b_ready), .rd_data(q_req)
    );

    rdm_back #(.NUM_FREQ(NUM_FREQ)) u_back (
        .aclk, .aresetn,
        .req_valid(q2b_valid), .req_ready(q2b_ready), .req(q_req),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_mags(mags), .res_cx(cx), .res_cy(cy), .res_last(m_tuser)
    );

    assign m_tdata = {4'd0, cy, cx, mags};

`ifndef ASSERT_OFF
    a_fifo_hs: assert property (@(posedge aclk) disable iff (!aresetn)
        f2q_valid && !f2q_ready |=> f2q_valid) else $error("queue request dropped");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
    a_back_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !q2b_ready) else $error("back end took request while busy");
`endif
endmodule

### src/rdm_front.sv
// ----------------------------------------------------------------------------
// rdm_front
// Line stores, 3x3 window and raster counters; emits interior windows.
// ----------------------------------------------------------------------------
module rdm_front
    import rdm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [CFG_W-1:0]   width_cfg,
    input  logic [CFG_W-1:0]   height_cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIX_W-1:0]   pixel,
    input  logic               sof,
    output logic               req_valid,
    input  logic               req_ready,
    output rdm_req_t           req
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1) > CFG_W ? $clog2(MAX_WIDTH + 1) : CFG_W;

    logic [PIX_W-1:0] mem_up [MAX_WIDTH];
    logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

    // stage A: read line stores
    logic             a_vld_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic [CW-1:0]    a_c_reg;
    logic [CW-1:0]    a_r_reg;
    logic [PIX_W-1:0] up_rd_reg, mid_rd_reg;
    logic [PIX_W-1:0] win_reg [9];
    logic [CW-1:0]    col_reg, row_reg, col_next, row_next;
    logic [CW-1:0]    w_eff, h_eff, c_now, r_now, c_inc;
    logic             acc, a_out_ok, interior;

    assign w_eff = (width_cfg < CFG_W'(3)) ? CW'(3) :
                   (CW'(width_cfg) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_cfg);
    assign h_eff = (height_cfg < CFG_W'(3)) ? CW'(3) :
                   (CW'(height_cfg) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_cfg);

    // stage A output goes into req register; stall whole front when req held
    assign a_out_ok = !req_valid || req_ready;
    assign in_ready = a_out_ok;
    assign acc      = in_valid && in_ready;

    assign c_now = sof ? '0 : col_reg;
    assign r_now = sof ? '0 : row_reg;
    assign c_inc = c_now + CW'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            if (c_inc >= w_eff) begin
                col_next = '0;
                row_next = (r_now + CW'(1) >= h_eff) ? '0 : r_now + CW'(1);
            end else begin
                col_next = c_inc;
                row_next = r_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            a_vld_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (a_out_ok) a_vld_reg <= acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            up_rd_reg  <= mem_up[c_now[AW-1:0]];
            mid_rd_reg <= mem_mid[c_now[AW-1:0]];
            mem_up[c_now[AW-1:0]]  <= mem_mid[c_now[AW-1:0]];
            mem_mid[c_now[AW-1:0]] <= pixel;
            a_pix_reg <= pixel;
            a_c_reg   <= c_now;
            a_r_reg   <= r_now;
        end
    end

    // window update and classification in stage B
    assign interior = a_r_reg >= CW'(2) && a_c_reg >= CW'(2)
                      && a_r_reg < h_eff && a_c_reg < w_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid <= 1'b0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end else if (a_out_ok) begin
            req_valid <= a_vld_reg && interior;
            if (a_vld_reg) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= up_rd_reg;
                win_reg[5] <= mid_rd_reg;
                win_reg[8] <= a_pix_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_out_ok && a_vld_reg) begin
            req.x0   <= mid_rd_reg;
            req.x1   <= up_rd_reg;
            req.x2   <= win_reg[2];
            req.x3   <= win_reg[1];
            req.x4   <= win_reg[4];
            req.x5   <= win_reg[7];
            req.x6   <= win_reg[8];
            req.x7   <= a_pix_reg;
            req.cx   <= POS_W'(a_c_reg - CW'(1));
            req.cy   <= POS_W'(a_r_reg - CW'(1));
            req.last <= (a_r_reg == h_eff - CW'(1)) && (a_c_reg == w_eff - CW'(1));
        end
    end
endmodule

### src/rdm_fifo.sv
// ----------------------------------------------------------------------------
// rdm_fifo
// Short queue between the window front and the DFT back end.
// ----------------------------------------------------------------------------
module rdm_fifo
    import rdm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  rdm_req_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output rdm_req_t rd_data
);
    rdm_req_t    q_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;
    logic        wr, rd;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = q_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, wr} - {2'b0, rd};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) q_reg[wp_reg] <= wr_data;
    end
endmodule

### src/rdm_back.sv
// ----------------------------------------------------------------------------
// rdm_back
// DFT butterflies, squared magnitude and bit-serial square root per bin.
// ----------------------------------------------------------------------------
module rdm_back
    import rdm_pkg::*;
#(
    parameter int NUM_FREQ = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    output logic               req_ready,
    input  rdm_req_t           req,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [8*NBINS-1:0] res_mags,
    output logic [POS_W-1:0]   res_cx,
    output logic [POS_W-1:0]   res_cy,
    output logic               res_last
);
    rdm_state_t state_reg, state_next;
    logic signed [AB_W-1:0] ra_reg [NBINS], rb_reg [NBINS], ia_reg [NBINS], ib_reg [NBINS];
    logic signed [Q_W-1:0]  re_reg [NBINS], im_reg [NBINS];
    logic [SQ_W-1:0]        v_reg [NBINS];
    logic [SQ_W:0]          rem_reg [NBINS];
    logic [ROOT_W-1:0]      root_reg [NBINS];
    logic [4:0]             step_reg;
    logic [1:0]             ph_reg;
    logic [POS_W-1:0]       cx_reg, cy_reg;
    logic                   last_reg;
    logic signed [AB_W-1:0] x [8];
    logic                   take;

    assign x[0] = AB_W'(req.x0); assign x[1] = AB_W'(req.x1);
    assign x[2] = AB_W'(req.x2); assign x[3] = AB_W'(req.x3);
    assign x[4] = AB_W'(req.x4); assign x[5] = AB_W'(req.x5);
    assign x[6] = AB_W'(req.x6); assign x[7] = AB_W'(req.x7);

    assign req_ready = state_reg == SQ_IDLE;
    assign take      = req_valid && req_ready;
    assign res_valid = state_reg == SQ_DONE;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE: if (take) state_next = SQ_LOAD;
            SQ_LOAD: if (ph_reg == 2'd2) state_next = SQ_RUN;
            SQ_RUN:  if (step_reg == 5'd30) state_next = SQ_DONE;
            SQ_DONE: if (res_ready) state_next = SQ_IDLE;
            default: state_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            ph_reg    <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= (state_reg == SQ_LOAD) ? ph_reg + 2'd1 : 2'd0;
            step_reg  <= (state_reg == SQ_RUN) ? step_reg + 5'd1 : 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ra_reg[0] <= x[0]+x[1]+x[2]+x[3]+x[4]+x[5]+x[6]+x[7];
            rb_reg[0] <= '0; ia_reg[0] <= '0; ib_reg[0] <= '0;
            ra_reg[1] <= x[0]-x[4]; rb_reg[1] <= x[1]-x[3]-x[5]+x[7];
            ia_reg[1] <= x[6]-x[2]; ib_reg[1] <= x[5]+x[7]-x[1]-x[3];
            ra_reg[2] <= x[0]-x[2]+x[4]-x[6]; rb_reg[2] <= '0;
            ia_reg[2] <= x[3]+x[7]-x[1]-x[5]; ib_reg[2] <= '0;
            ra_reg[3] <= x[0]-x[4]; rb_reg[3] <= x[3]+x[5]-x[1]-x[7];
            ia_reg[3] <= x[2]-x[6]; ib_reg[3] <= x[5]+x[7]-x[1]-x[3];
            ra_reg[4] <= x[0]-x[1]+x[2]-x[3]+x[4]-x[5]+x[6]-x[7];
            rb_reg[4] <= '0; ia_reg[4] <= '0; ib_reg[4] <= '0;
            cx_reg   <= req.cx;
            cy_reg   <= req.cy;
            last_reg <= req.last;
        end
        for (int b = 0; b < NBINS; b++) begin
            if (state_reg == SQ_LOAD && ph_reg == 2'd0) begin
                re_reg[b] <= (Q_W'(ra_reg[b]) <<< 16) + Q_W'(rb_reg[b]) * Q_W'(COS45_Q16);
                im_reg[b] <= (Q_W'(ia_reg[b]) <<< 16) + Q_W'(ib_reg[b]) * Q_W'(COS45_Q16);
            end
            if (state_reg == SQ_LOAD && ph_reg == 2'd1) begin
                v_reg[b] <= SQ_W'(64'(re_reg[b]) * 64'(re_reg[b]))
                          + SQ_W'(64'(im_reg[b]) * 64'(im_reg[b]));
            end
            if (state_reg == SQ_LOAD && ph_reg == 2'd2) begin
                rem_reg[b]  <= '0;
                root_reg[b] <= '0;
            end
            if (state_reg == SQ_RUN) begin
                // one result bit per cycle, restoring
                logic [SQ_W:0] trial, r2;
                r2    = {rem_reg[b][SQ_W-2:0], v_reg[b][SQ_W-1 -: 2]};
                trial = {root_reg[b], 2'b01};
                if (r2 >= trial) begin
                    rem_reg[b]  <= r2 - trial;
                    root_reg[b] <= {root_reg[b][ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[b]  <= r2;
                    root_reg[b] <= {root_reg[b][ROOT_W-2:0], 1'b0};
                end
                v_reg[b] <= {v_reg[b][SQ_W-3:0], 2'b00};
            end
        end
    end

    always_comb begin
        for (int b = 0; b < NBINS; b++) begin
            if (b >= NUM_FREQ)
                res_mags[b*8 +: 8] = 8'd0;
            else if (|root_reg[b][ROOT_W-1:27])
                res_mags[b*8 +: 8] = 8'hFF;
            else
                res_mags[b*8 +: 8] = root_reg[b][26:19];
        end
    end

    assign res_cx   = cx_reg;
    assign res_cy   = cy_reg;
    assign res_last = last_reg;
endmodule
